/* hdl/two_level_feedback_scheduler_core_defines.svh */
// ----------------------------------------------------------------------------
// Two-level feedback scheduler assertion macros
// Shared property forms used by the scheduler core.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_FEEDBACK_SCHEDULER_CORE_DEFINES_SVH
`define TWO_LEVEL_FEEDBACK_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TFS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/tfs_pkg.sv */
// ----------------------------------------------------------------------------
// Two-level feedback scheduler package
// Transfer types, operation codes and the per-task record layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfs_pkg;

  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_PICK = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  localparam logic [1:0] M_NONE = 2'd0;
  localparam logic [1:0] M_Q1   = 2'd1;
  localparam logic [1:0] M_Q2   = 2'd2;

  localparam logic [1:0] LEVEL_ONE_CODE = 2'd1;
  localparam logic [7:0] RESET_SLICE    = 8'd10;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] task_id;
    logic       new_task;
    logic [1:0] level_in;
    logic       curr_valid;
    logic [5:0] curr_task;
  } in_t;

  typedef struct packed {
    logic       picked_valid;
    logic [5:0] picked_task;
    logic       resched_flag;
    logic [5:0] resched_task;
    logic [6:0] running_count;
    logic       status;
  } out_t;

  typedef struct packed {
    logic       level;
    logic [7:0] slice;
    logic [1:0] member;
  } task_rec_t;

endpackage

/* hdl/tfs_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/two_level_feedback_scheduler_core.sv */
// ----------------------------------------------------------------------------
// Two-level feedback scheduler core
// Run queue of two linked FIFO lists over task ids, held in RAMs.
// ----------------------------------------------------------------------------
//   channel   ports                      direction
//   command   start, busy, cmd           in (busy out)
//   result    done, result               out
//   config    cfg_we, cfg_data           in
//
// A command goes from transfer through the read and evaluate states to the done
// strobe; an accepted enqueue or a demoting tick of a queued task also passes
// through the two append states of the sequencer over the task and link RAMs.
// After reset a clearing pass writes every entry of the task RAM;
// busy stays high during it.
// The result is valid for the single cycle in which done is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_level_feedback_scheduler_core_defines.svh"

module two_level_feedback_scheduler_core
  import tfs_pkg::*;
#(
  parameter int MAX_TASKS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  in_t        cmd,
  output logic       done,
  output out_t       result,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  localparam int AW = $clog2(MAX_TASKS);
  localparam int RW = $bits(task_rec_t);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_APP1  = 3'd4;
  localparam logic [2:0] S_APP2  = 3'd5;

  logic [2:0]    state, state_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  in_t           req, req_next;
  logic [7:0]    time_slice;
  logic [AW-1:0] head [2];
  logic [AW-1:0] head_next [2];
  logic [AW-1:0] tail [2];
  logic [AW-1:0] tail_next [2];
  logic [1:0]    qbusy, qbusy_next;
  logic [6:0]    qtotal, qtotal_next;
  logic          app_q, app_q_next;
  logic [AW-1:0] app_tail, app_tail_next;
  logic          app_link, app_link_next;
  logic          chk, chk_next;
  logic          fwd, fwd_next;
  logic          self_lvl, self_lvl_next;
  logic          done_next;
  out_t          result_next;

  logic          tk_we;
  logic [AW-1:0] tk_waddr, tk_raddr;
  task_rec_t     tk_wdata, rec;
  logic [RW-1:0] tk_rdata;
  logic          nx_we, pv_we;
  logic [AW-1:0] nx_waddr, nx_wdata, nx_rdata;
  logic [AW-1:0] pv_waddr, pv_wdata, pv_rdata;

  logic          t_ok, ct_ok, rm, rq, lvl, ct_lvl;
  logic [AW-1:0] t_a, ct_a;
  logic [7:0]    sl;

  assign busy  = (state != S_IDLE);
  assign rec   = task_rec_t'(tk_rdata);
  assign t_ok  = int'(req.task_id) < MAX_TASKS;
  assign ct_ok = int'(req.curr_task) < MAX_TASKS;
  assign t_a   = AW'(req.task_id);
  assign ct_a  = AW'(req.curr_task);

  tfs_ram #(.WIDTH(RW), .DEPTH(MAX_TASKS)) u_task_ram (
    .clk(clk), .we(tk_we), .waddr(tk_waddr), .wdata(tk_wdata),
    .raddr(tk_raddr), .rdata(tk_rdata)
  );

  tfs_ram #(.WIDTH(AW), .DEPTH(MAX_TASKS)) u_next_ram (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(t_a), .rdata(nx_rdata)
  );

  tfs_ram #(.WIDTH(AW), .DEPTH(MAX_TASKS)) u_prev_ram (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(t_a), .rdata(pv_rdata)
  );

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    req_next      = req;
    head_next     = head;
    tail_next     = tail;
    qbusy_next    = qbusy;
    qtotal_next   = qtotal;
    app_q_next    = app_q;
    app_tail_next = app_tail;
    app_link_next = app_link;
    chk_next      = chk;
    fwd_next      = fwd;
    self_lvl_next = self_lvl;
    done_next     = 1'b0;
    result_next   = result;
    tk_we         = 1'b0;
    tk_waddr      = t_a;
    tk_wdata      = rec;
    tk_raddr      = t_a;
    nx_we         = 1'b0;
    nx_waddr      = t_a;
    nx_wdata      = t_a;
    pv_we         = 1'b0;
    pv_waddr      = t_a;
    pv_wdata      = t_a;
    rm            = 1'b0;
    rq            = (rec.member == M_Q2);
    lvl           = req.new_task ? (req.level_in != LEVEL_ONE_CODE) : rec.level;
    sl            = req.new_task ? time_slice : rec.slice;
    ct_lvl        = fwd ? self_lvl : rec.level;
    case (state)
      S_CLEAR: begin
        tk_we         = 1'b1;
        tk_waddr      = clr_addr;
        tk_wdata      = '{level: 1'b0, slice: RESET_SLICE, member: M_NONE};
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(MAX_TASKS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_next   = cmd;
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        result_next               = '0;
        result_next.running_count = qtotal;
        chk_next                  = 1'b0;
        done_next                 = 1'b1;
        state_next                = S_IDLE;
        case (req.op)
          OP_ENQ: begin
            if (!t_ok || rec.member != M_NONE) begin
              result_next.status = 1'b1;
            end else begin
              tk_we                     = 1'b1;
              tk_wdata                  = '{level: lvl, slice: sl,
                                            member: lvl ? M_Q2 : M_Q1};
              tk_raddr                  = ct_a;
              app_q_next                = lvl;
              chk_next                  = !lvl && req.curr_valid && ct_ok;
              fwd_next                  = (req.curr_task == req.task_id);
              self_lvl_next             = lvl;
              qtotal_next               = qtotal + 7'd1;
              result_next.running_count = qtotal + 7'd1;
              done_next                 = 1'b0;
              state_next                = S_APP1;
            end
          end
          OP_DEQ: begin
            if (!t_ok || rec.member == M_NONE) begin
              result_next.status = 1'b1;
            end else begin
              rm                        = 1'b1;
              tk_we                     = 1'b1;
              tk_wdata                  = '{level: rec.level, slice: rec.slice,
                                            member: M_NONE};
              qtotal_next               = qtotal - 7'd1;
              result_next.running_count = qtotal - 7'd1;
            end
          end
          OP_PICK: begin
            if (qbusy[0]) begin
              result_next.picked_valid = 1'b1;
              result_next.picked_task  = 6'(head[0]);
            end else if (qbusy[1]) begin
              result_next.picked_valid = 1'b1;
              result_next.picked_task  = 6'(head[1]);
            end
          end
          default: begin
            if (!t_ok) begin
              result_next.status = 1'b1;
            end else if (!rec.level) begin
              tk_we = 1'b1;
              if (rec.slice <= 8'd1) begin
                tk_wdata = '{level: 1'b1, slice: time_slice,
                             member: (rec.member != M_NONE) ? M_Q2 : M_NONE};
                result_next.resched_flag = 1'b1;
                result_next.resched_task = req.task_id;
                if (rec.member != M_NONE) begin
                  rm         = 1'b1;
                  app_q_next = 1'b1;
                  done_next  = 1'b0;
                  state_next = S_APP1;
                end
              end else begin
                tk_wdata = '{level: rec.level, slice: rec.slice - 8'd1,
                             member: rec.member};
              end
            end else if (qbusy[0]) begin
              result_next.resched_flag = 1'b1;
              result_next.resched_task = req.task_id;
            end
          end
        endcase
        if (rm) begin
          if (head[rq] == t_a && tail[rq] == t_a) begin
            qbusy_next[rq] = 1'b0;
          end else if (head[rq] == t_a) begin
            head_next[rq] = nx_rdata;
            pv_we         = 1'b1;
            pv_waddr      = nx_rdata;
            pv_wdata      = nx_rdata;
          end else if (tail[rq] == t_a) begin
            tail_next[rq] = pv_rdata;
            nx_we         = 1'b1;
            nx_waddr      = pv_rdata;
            nx_wdata      = pv_rdata;
          end else begin
            nx_we    = 1'b1;
            nx_waddr = pv_rdata;
            nx_wdata = nx_rdata;
            pv_we    = 1'b1;
            pv_waddr = nx_rdata;
            pv_wdata = pv_rdata;
          end
        end
      end
      S_APP1: begin
        pv_we             = 1'b1;
        pv_wdata          = qbusy[app_q] ? tail[app_q] : t_a;
        nx_we             = 1'b1;
        app_link_next     = qbusy[app_q];
        app_tail_next     = tail[app_q];
        if (!qbusy[app_q]) begin
          head_next[app_q] = t_a;
        end
        qbusy_next[app_q] = 1'b1;
        tail_next[app_q]  = t_a;
        if (chk && ct_lvl) begin
          result_next.resched_flag = 1'b1;
          result_next.resched_task = req.curr_task;
        end
        state_next = S_APP2;
      end
      S_APP2: begin
        nx_we      = app_link;
        nx_waddr   = app_tail;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      time_slice <= RESET_SLICE;
      qbusy      <= 2'b00;
      qtotal     <= '0;
      done       <= 1'b0;
      chk        <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      qbusy    <= qbusy_next;
      qtotal   <= qtotal_next;
      done     <= done_next;
      chk      <= chk_next;
      if (cfg_we) begin
        time_slice <= cfg_data;
      end
    end
    req      <= req_next;
    head     <= head_next;
    tail     <= tail_next;
    app_q    <= app_q_next;
    app_tail <= app_tail_next;
    app_link <= app_link_next;
    fwd      <= fwd_next;
    self_lvl <= self_lvl_next;
    result   <= result_next;
  end

  `TFS_ASSERT_SAME(a_done_idle, done, !busy, "Result strobe while the sequencer is busy.")
  `TFS_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "Transfer did not start work.")
  `TFS_ASSERT_NEXT(a_done_pulse, done, !done, "Result strobe held longer than one cycle.")
  `TFS_ASSERT_SAME(a_pick_found, done && result.picked_valid, qbusy != 2'b00, "Pick reported a task from empty queues.")

endmodule
